// File: rtl/core/ray_disc_intersection_macros.svh
// Assertion macros shared by the ray against disc intersection block.
`ifndef RAY_DISC_INTERSECTION_MACROS_SVH
`define RAY_DISC_INTERSECTION_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define RDI_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define RDI_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/core/rdi_pkg.sv
// Package with widths, codes and helpers of the ray against disc intersection block.
package rdi_pkg;

  localparam int FRAC_BITS = 16;
  // Quotient bits of t (magnitude below 2^31).
  localparam int QB   = 31;
  // Width of a dot product term after the fraction shift.
  localparam int TW   = 64 - FRAC_BITS;
  // Signed width of a three-term dot product and its magnitude width.
  localparam int SW   = 66 - FRAC_BITS;
  localparam int DW   = SW - 1;
  // Partial remainder width of the divider.
  localparam int RW   = DW + QB;
  // Width used for saturation to 32 bits.
  localparam int SATW = TW + 1;
  // Number of root bits from the square root pipeline.
  localparam int RB   = 32;

  localparam logic [31:0] QMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] QMIN = 32'h8000_0000;
  localparam logic [30:0] DMAX = 31'h7FFF_FFFF;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_NORMAL_X = 3'd3;
  localparam logic [2:0] REG_NORMAL_Y = 3'd4;
  localparam logic [2:0] REG_NORMAL_Z = 3'd5;
  localparam logic [2:0] REG_RADIUS   = 3'd6;
  localparam logic [2:0] REG_EPSILON  = 3'd7;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_BEHIND   = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_e;

  // Ray payload carried through the front end and the divider.
  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
  } ray_t;

  // One divider stage.
  typedef struct packed {
    ray_t            ray;
    logic            neg;
    logic            ovf;
    logic            par;
    logic [RW-1:0]   rem;
    logic [DW-1:0]   dvs;
    logic [QB-1:0]   quo;
  } div_t;

  // Hit point payload behind the divider.
  typedef struct packed {
    logic             par;
    logic             behind;
    logic [31:0]      t;
    logic [2:0][31:0] pt;
  } tail_t;

  // One square root stage.
  typedef struct packed {
    tail_t       tail;
    logic [63:0] x;
    logic [63:0] res;
  } sqrt_t;

  localparam logic signed [SATW-1:0] SAT_HI = {{(SATW-32){1'b0}}, QMAX};
  localparam logic signed [SATW-1:0] SAT_LO = {{(SATW-32){1'b1}}, QMIN};

  function automatic logic [31:0] sat32(input logic signed [SATW-1:0] v);
    logic [31:0] r;
    if (v > SAT_HI) r = QMAX;
    else if (v < SAT_LO) r = QMIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: rtl/core/ray_disc_intersection.sv
// Top level of the ray against disc intersection block, a fully pipelined datapath.
//
//  channel   signals                                   direction  transfer when
//  ray in    start_i, busy_o, origin_*_i, dir_*_i      in         start_i && !busy_o
//  result    done_o, status_o, hit_t_o, point_*_o,     out        done_o (one cycle)
//            center_distance_o
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i          in         cfg_we_i
//
// One ray enters per clock cycle. The pipeline holds the 31 one-bit stages of
// the t divider and the 32 stages of the distance square root, plus eleven
// arithmetic stages around them.
// busy_o is always low: the result side cannot stall, so the pipeline never holds.
// Reset clears the valid bits and loads the disc registers with their defaults.
`include "ray_disc_intersection_macros.svh"

module ray_disc_intersection (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] hit_t_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o,
  output logic [30:0]        center_distance_o
);

  localparam int QB   = rdi_pkg::QB;
  localparam int DW   = rdi_pkg::DW;
  localparam int SW   = rdi_pkg::SW;
  localparam int RW   = rdi_pkg::RW;
  localparam int SATW = rdi_pkg::SATW;
  localparam int RB   = rdi_pkg::RB;
  localparam int FB   = rdi_pkg::FRAC_BITS;

  // Disc configuration. Writes must arrive only while the pipeline is empty; the
  // block does not enforce this, and every stage reads these registers directly.
  logic [2:0][31:0] center_q, normal_q;
  logic [30:0]      radius_q;
  logic [15:0]      eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      normal_q <= {32'h0001_0000, 32'h0, 32'h0};
      radius_q <= 31'h0001_0000;
      eps_q    <= 16'h0001;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rdi_pkg::REG_CENTER_X: center_q[0] <= cfg_wdata_i;
        rdi_pkg::REG_CENTER_Y: center_q[1] <= cfg_wdata_i;
        rdi_pkg::REG_CENTER_Z: center_q[2] <= cfg_wdata_i;
        rdi_pkg::REG_NORMAL_X: normal_q[0] <= cfg_wdata_i;
        rdi_pkg::REG_NORMAL_Y: normal_q[1] <= cfg_wdata_i;
        rdi_pkg::REG_NORMAL_Z: normal_q[2] <= cfg_wdata_i;
        rdi_pkg::REG_RADIUS:   radius_q    <= cfg_wdata_i[30:0];
        rdi_pkg::REG_EPSILON:  eps_q       <= cfg_wdata_i[15:0];
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic         in_xfer;
  rdi_pkg::ray_t in_ray;
  assign in_xfer = start_i && !busy_o;
  assign in_ray.org = {origin_z_i, origin_y_i, origin_x_i};
  assign in_ray.dir = {dir_z_i, dir_y_i, dir_x_i};

  // Stage 1: normal times direction, and center minus origin saturated.
  logic               v1_q;
  rdi_pkg::ray_t      ray1_q;
  logic signed [63:0] pnd1_d [3], pnd1_q [3];
  logic [31:0]        rel1_d [3], rel1_q [3];

  always_comb begin
    logic signed [32:0] diff;
    for (int i = 0; i < 3; i++) begin
      pnd1_d[i] = $signed(normal_q[i]) * $signed(in_ray.dir[i]);
      diff = $signed({center_q[i][31], center_q[i]}) -
             $signed({in_ray.org[i][31], in_ray.org[i]});
      rel1_d[i] = rdi_pkg::sat32({{(SATW-33){diff[32]}}, diff});
    end
  end

  // Stage 2: denominator sum, and relative vector times normal.
  logic               v2_q;
  rdi_pkg::ray_t      ray2_q;
  logic signed [SW-1:0] den2_d, den2_q;
  logic signed [63:0] prn2_d [3], prn2_q [3];

  always_comb begin
    logic signed [63:0] s;
    s = (pnd1_q[0] >>> FB) + (pnd1_q[1] >>> FB) + (pnd1_q[2] >>> FB);
    den2_d = s[SW-1:0];
    for (int i = 0; i < 3; i++) begin
      prn2_d[i] = $signed(rel1_q[i]) * $signed(normal_q[i]);
    end
  end

  // Stage 3: numerator sum, magnitudes, sign of t and the parallel test.
  logic          v3_q;
  rdi_pkg::ray_t ray3_q;
  logic [DW-1:0] dmag3_d, dmag3_q, nmag3_d, nmag3_q;
  logic          neg3_d, neg3_q, par3_d, par3_q;

  always_comb begin
    logic signed [63:0] s;
    logic signed [SW-1:0] num, nneg, dneg;
    s    = (prn2_q[0] >>> FB) + (prn2_q[1] >>> FB) + (prn2_q[2] >>> FB);
    num  = s[SW-1:0];
    nneg = -num;
    dneg = -den2_q;
    nmag3_d = num[SW-1] ? nneg[DW-1:0] : num[DW-1:0];
    dmag3_d = den2_q[SW-1] ? dneg[DW-1:0] : den2_q[DW-1:0];
    neg3_d  = num[SW-1] != den2_q[SW-1];
    par3_d  = dmag3_d <= {{(DW-16){1'b0}}, eps_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_xfer;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ray1_q  <= in_ray;
    pnd1_q  <= pnd1_d;
    rel1_q  <= rel1_d;
    ray2_q  <= ray1_q;
    den2_q  <= den2_d;
    prn2_q  <= prn2_d;
    ray3_q  <= ray2_q;
    dmag3_q <= dmag3_d;
    nmag3_q <= nmag3_d;
    neg3_q  <= neg3_d;
    par3_q  <= par3_d;
  end

  // Divider: entry stage scales the numerator and checks for overflow of t,
  // then one quotient bit per stage, most significant first.
  logic          dv_q  [QB+1];
  rdi_pkg::div_t div_q [QB+1];
  rdi_pkg::div_t div0_d;

  always_comb begin
    logic [DW+QB-FB-1:0] nw, dw;
    nw = {{(QB-FB){1'b0}}, nmag3_q};
    dw = {{(QB-FB){1'b0}}, dmag3_q} << (QB - FB);
    div0_d.ray = ray3_q;
    div0_d.neg = neg3_q;
    div0_d.par = par3_q;
    div0_d.ovf = nw >= dw;
    div0_d.rem = {{QB{1'b0}}, nmag3_q} << FB;
    div0_d.dvs = dmag3_q;
    div0_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else dv_q[0] <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    div_q[0] <= div0_d;
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int SH = QB - 1 - k;
    rdi_pkg::div_t div_d;

    always_comb begin
      logic [RW-1:0] dsh;
      div_d = div_q[k];
      dsh = {{QB{1'b0}}, div_q[k].dvs} << SH;
      if (div_q[k].rem >= dsh) begin
        div_d.rem = div_q[k].rem - dsh;
        div_d.quo[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[k+1] <= 1'b0;
      else dv_q[k+1] <= dv_q[k];
    end

    always_ff @(posedge clk_i) begin
      div_q[k+1] <= div_d;
    end
  end

  // Stage T: signed, saturated t and the behind test.
  rdi_pkg::div_t dlast;
  assign dlast = div_q[QB];

  logic          vt_q;
  rdi_pkg::ray_t rayt_q;
  rdi_pkg::tail_t tailt_d, tailt_q;

  always_comb begin
    logic [31:0] qv;
    qv = {1'b0, dlast.quo};
    tailt_d.par = dlast.par;
    tailt_d.pt  = '0;
    if (dlast.ovf) tailt_d.t = dlast.neg ? rdi_pkg::QMIN : rdi_pkg::QMAX;
    else tailt_d.t = dlast.neg ? -qv : qv;
    tailt_d.behind = $signed(tailt_d.t) <= $signed({16'h0, eps_q});
  end

  // Stage M: direction times t.
  logic               vm_q;
  rdi_pkg::ray_t      raym_q;
  rdi_pkg::tail_t     tailm_q;
  logic signed [63:0] pdt_d [3], pdt_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pdt_d[i] = $signed(rayt_q.dir[i]) * $signed(tailt_q.t);
    end
  end

  // Stage P: hit point, saturated.
  logic           vp_q;
  rdi_pkg::tail_t tailp_d, tailp_q;

  always_comb begin
    logic signed [63:0] sh;
    logic signed [SATW-1:0] sum;
    tailp_d = tailm_q;
    for (int i = 0; i < 3; i++) begin
      sh  = pdt_q[i] >>> FB;
      sum = sh[SATW-1:0] + {{(SATW-32){raym_q.org[i][31]}}, raym_q.org[i]};
      tailp_d.pt[i] = rdi_pkg::sat32(sum);
    end
  end

  // Stage D: clamped magnitudes of the point minus center.
  logic           vd_q;
  rdi_pkg::tail_t taild_q;
  logic [31:0]    mag_d [3], mag_q [3];

  always_comb begin
    logic signed [32:0] diff;
    logic [32:0] m;
    for (int i = 0; i < 3; i++) begin
      diff = $signed({tailp_q.pt[i][31], tailp_q.pt[i]}) -
             $signed({center_q[i][31], center_q[i]});
      m = diff[32] ? -diff : diff;
      mag_d[i] = (m > 33'h0_8000_0000) ? 32'h8000_0000 : m[31:0];
    end
  end

  // Stage Q: squares.
  logic           vs_q;
  rdi_pkg::tail_t tails_q;
  logic [63:0]    sq_d [3], sq_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = 64'(mag_q[i]) * 64'(mag_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= 1'b0;
      vm_q <= 1'b0;
      vp_q <= 1'b0;
      vd_q <= 1'b0;
      vs_q <= 1'b0;
    end else begin
      vt_q <= dv_q[QB];
      vm_q <= vt_q;
      vp_q <= vm_q;
      vd_q <= vp_q;
      vs_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rayt_q  <= dlast.ray;
    tailt_q <= tailt_d;
    raym_q  <= rayt_q;
    tailm_q <= tailt_q;
    pdt_q   <= pdt_d;
    tailp_q <= tailp_d;
    taild_q <= tailp_q;
    mag_q   <= mag_d;
    tails_q <= taild_q;
    sq_q    <= sq_d;
  end

  // Square root: the sum of squares enters stage zero, then one root bit per stage.
  logic           rv_q [RB+1];
  rdi_pkg::sqrt_t rt_q [RB+1];
  rdi_pkg::sqrt_t rt0_d;

  always_comb begin
    rt0_d.tail = tails_q;
    rt0_d.x    = sq_q[0] + sq_q[1] + sq_q[2];
    rt0_d.res  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q[0] <= 1'b0;
    else rv_q[0] <= vs_q;
  end

  always_ff @(posedge clk_i) begin
    rt_q[0] <= rt0_d;
  end

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (2 * (RB - 1 - k));
    rdi_pkg::sqrt_t rt_d;

    always_comb begin
      logic [64:0] trial;
      rt_d  = rt_q[k];
      trial = {1'b0, rt_q[k].res} + {1'b0, BIT};
      if ({1'b0, rt_q[k].x} >= trial) begin
        rt_d.x   = rt_q[k].x - trial[63:0];
        rt_d.res = (rt_q[k].res >> 1) + BIT;
      end else begin
        rt_d.res = rt_q[k].res >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) rv_q[k+1] <= 1'b0;
      else rv_q[k+1] <= rv_q[k];
    end

    always_ff @(posedge clk_i) begin
      rt_q[k+1] <= rt_d;
    end
  end

  // Output stage: status, miss values and saturation of the distance.
  rdi_pkg::sqrt_t rlast;
  assign rlast = rt_q[RB];

  logic             done_q;
  rdi_pkg::status_e status_d, status_q;
  logic [31:0]      hit_t_d, hit_t_q;
  logic [2:0][31:0] pt_d, pt_q;
  logic [30:0]      dist_d, dist_q;

  always_comb begin
    logic hit;
    hit = rlast.res <= {33'h0, radius_q};
    priority if (rlast.tail.par) status_d = rdi_pkg::ST_PARALLEL;
    else if (rlast.tail.behind) status_d = rdi_pkg::ST_BEHIND;
    else if (hit) status_d = rdi_pkg::ST_HIT;
    else status_d = rdi_pkg::ST_OUTSIDE;
    hit_t_d = (status_d == rdi_pkg::ST_HIT) ? rlast.tail.t : rdi_pkg::QMAX;
    if (rlast.tail.par || rlast.tail.behind) begin
      pt_d   = '0;
      dist_d = rdi_pkg::DMAX;
    end else begin
      pt_d   = rlast.tail.pt;
      dist_d = (rlast.res > 64'h7FFF_FFFF) ? rdi_pkg::DMAX : rlast.res[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= rv_q[RB];
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    hit_t_q  <= hit_t_d;
    pt_q     <= pt_d;
    dist_q   <= dist_d;
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign hit_t_o           = hit_t_q;
  assign point_x_o         = pt_q[0];
  assign point_y_o         = pt_q[1];
  assign point_z_o         = pt_q[2];
  assign center_distance_o = dist_q;

  // A miss of any kind reports the maximum t.
  `RDI_ASSERT_NOW(a_miss_t_max, done_o && status_o != rdi_pkg::ST_HIT, hit_t_o == rdi_pkg::QMAX, "miss without maximum t")
  // Parallel and behind rays report no point and the maximum distance.
  `RDI_ASSERT_NOW(a_nohit_fields, done_o && (status_o == rdi_pkg::ST_PARALLEL || status_o == rdi_pkg::ST_BEHIND), point_x_o == 32'h0 && point_y_o == 32'h0 && point_z_o == 32'h0 && center_distance_o == rdi_pkg::DMAX, "parallel or behind result with point data")
  // A hit lies within the radius and strictly in front of the origin.
  `RDI_ASSERT_NOW(a_hit_valid, done_o && status_o == rdi_pkg::ST_HIT, center_distance_o <= radius_q && $signed(hit_t_o) > $signed({16'h0, eps_q}), "hit outside radius or behind")
  // An accepted ray always reaches the first stage.
  `RDI_ASSERT_NEXT(a_enter, start_i && !busy_o, v1_q, "accepted ray lost at pipeline entry")

endmodule
